// File: rtl/core/utf8ct_pkg.sv
`timescale 1ns / 1ps

package utf8ct_pkg;

  localparam int unsigned WideEntriesDef = 32;
  localparam int unsigned QDepth         = 4;
  localparam int unsigned QCntW          = $clog2(QDepth + 1);

  localparam logic [20:0] CpMax     = 21'h10FFFF;
  localparam logic [7:0]  AsciiLast = 8'h7f;

  typedef enum logic [2:0] {
    CMD_TEXT      = 3'd0,
    CMD_EOR       = 3'd1,
    CMD_SET_ASCII = 3'd2,
    CMD_SET_WIDE  = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  // One resolved burst of output words.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic            term;
    logic            full;
  } job_t;

endpackage

// File: rtl/core/utf8ct_front.sv
`timescale 1ns / 1ps

module utf8ct_front #(
  parameter int unsigned WideEntries = utf8ct_pkg::WideEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   cmd_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [20:0]                  key_i,
  input  logic [20:0]                  value_i,
  input  logic                         drop_i,
  input  logic [utf8ct_pkg::QCntW-1:0] q_count_i,
  output logic                         q_push_o,
  output utf8ct_pkg::job_t             q_job_o
);
  import utf8ct_pkg::*;

  localparam int unsigned IdxW  = (WideEntries > 1) ? $clog2(WideEntries) : 1;
  localparam int unsigned UsedW = $clog2(WideEntries + 1);

  typedef enum logic [1:0] {K_ASCII, K_WIDE, K_RAW, K_FULL} kind_e;

  logic [2:0][7:0]  pend_q;
  logic [1:0]       pcnt_q;
  logic [2:0]       elen_q;
  logic [UsedW-1:0] used_q;
  logic [127:0]     avld_q;
  logic [21:0]      ascii_mem [128];
  logic [21:0]      wide_mem [WideEntries];
  logic [20:0]      wide_key_q [WideEntries];

  logic             s1_vld_q;
  kind_e            s1_kind_q;
  logic             s1_hit_q;
  logic             s1_avld_q;
  logic [3:0][7:0]  s1_bytes_q;
  logic [2:0]       s1_n_q;
  logic             s1_term_q;
  logic [21:0]      ascii_rd_q;
  logic [21:0]      wide_rd_q;

  logic [QCntW:0]   occ;
  logic             accept;
  cmd_e             cmd;
  logic [3:0][7:0]  seq_b;
  logic             seq_done;
  logic [2:0]       seq_n;
  logic [2:0]       lead_len;
  logic [20:0]      cp;
  logic [20:0]      look_key;
  logic             hit;
  logic [IdxW-1:0]  hit_idx;
  logic [21:0]      entry;

  assign occ        = {1'b0, q_count_i} + (QCntW + 1)'(s1_vld_q);
  assign in_ready_o = occ < (QCntW + 1)'(QDepth);
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(cmd_i);
  assign entry      = {drop_i, value_i};

  always_comb begin
    if (data_byte_i < 8'hC0 || data_byte_i >= 8'hF8) lead_len = 3'd1;
    else if (data_byte_i < 8'hE0)                    lead_len = 3'd2;
    else if (data_byte_i < 8'hF0)                    lead_len = 3'd3;
    else                                             lead_len = 3'd4;
  end

  // Gather the sequence as it would stand with the current byte appended.
  always_comb begin
    seq_b         = {8'h00, pend_q};
    seq_b[pcnt_q] = data_byte_i;
    seq_done      = (pcnt_q != 2'd0) && (({1'b0, pcnt_q} + 3'd1) >= elen_q);
    seq_n         = (pcnt_q != 2'd0) ? elen_q : 3'd1;
    case (seq_n)
      3'd2:    cp = {10'd0, seq_b[0][4:0], seq_b[1][5:0]};
      3'd3:    cp = {5'd0, seq_b[0][3:0], seq_b[1][5:0], seq_b[2][5:0]};
      3'd4:    cp = {seq_b[0][2:0], seq_b[1][5:0], seq_b[2][5:0], seq_b[3][5:0]};
      default: cp = {13'd0, seq_b[0]};
    endcase
  end

  // Associative compare over the filled part of the wide table; lowest hit wins.
  assign look_key = (cmd == CMD_SET_WIDE) ? key_i : cp;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = WideEntries - 1; i >= 0; i--) begin
      if ((UsedW'(i) < used_q) && (wide_key_q[i] == look_key)) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q   <= '0;
      elen_q   <= '0;
      used_q   <= '0;
      avld_q   <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= 1'b0;
      if (accept) begin
        unique case (cmd)
          CMD_TEXT: begin
            if (pcnt_q != 2'd0) begin
              if (seq_done) begin
                s1_vld_q <= 1'b1;
                pcnt_q   <= '0;
                elen_q   <= '0;
              end else begin
                pcnt_q <= pcnt_q + 2'd1;
              end
            end else if (data_byte_i <= AsciiLast || lead_len == 3'd1) begin
              s1_vld_q <= 1'b1;
            end else begin
              pcnt_q <= 2'd1;
              elen_q <= lead_len;
            end
          end
          CMD_EOR: begin
            s1_vld_q <= 1'b1;
            pcnt_q   <= '0;
            elen_q   <= '0;
          end
          CMD_SET_ASCII: begin
            if (key_i < 21'd128) avld_q[key_i[6:0]] <= 1'b1;
          end
          CMD_SET_WIDE: begin
            if (!hit) begin
              if (used_q < UsedW'(WideEntries)) used_q <= used_q + UsedW'(1);
              else                              s1_vld_q <= 1'b1;
            end
          end
          CMD_CLEAR: begin
            avld_q <= '0;
            used_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ascii_rd_q <= ascii_mem[data_byte_i[6:0]];
      wide_rd_q  <= wide_mem[hit_idx];
      s1_avld_q  <= avld_q[data_byte_i[6:0]];
      s1_hit_q   <= hit;
      s1_term_q  <= 1'b0;
      s1_bytes_q <= seq_b;
      s1_n_q     <= seq_n;
      s1_kind_q  <= K_WIDE;
      unique case (cmd)
        CMD_TEXT: begin
          if (pcnt_q != 2'd0) begin
            if (!seq_done) pend_q[pcnt_q] <= data_byte_i;
          end else if (data_byte_i <= AsciiLast) begin
            s1_kind_q <= K_ASCII;
          end else if (lead_len != 3'd1) begin
            pend_q[0] <= data_byte_i;
          end
        end
        CMD_EOR: begin
          s1_kind_q  <= K_RAW;
          s1_bytes_q <= {8'h00, pend_q};
          s1_n_q     <= {1'b0, pcnt_q};
          s1_term_q  <= 1'b1;
        end
        CMD_SET_ASCII: begin
          if (key_i < 21'd128) ascii_mem[key_i[6:0]] <= entry;
        end
        CMD_SET_WIDE: begin
          s1_kind_q <= K_FULL;
          if (hit) begin
            wide_mem[hit_idx] <= entry;
          end else if (used_q < UsedW'(WideEntries)) begin
            wide_key_q[used_q[IdxW-1:0]] <= key_i;
            wide_mem[used_q[IdxW-1:0]]   <= entry;
          end
        end
        default: ;
      endcase
    end
  end

  // Resolve the looked-up entry into output words.
  logic [21:0] ent;
  logic [20:0] ecp;
  job_t        job;

  always_comb begin
    ent = (s1_kind_q == K_ASCII) ?
          (s1_avld_q ? ascii_rd_q : {15'd0, s1_bytes_q[0][6:0]}) : wide_rd_q;
    ecp = ent[20:0];
    job = '0;
    case (s1_kind_q)
      K_FULL: begin
        job.n    = 3'd1;
        job.full = 1'b1;
      end
      K_RAW: begin
        job.bytes                 = s1_bytes_q;
        job.bytes[s1_n_q[1:0]]    = 8'h00;
        job.n                     = s1_n_q + 3'd1;
        job.term                  = s1_term_q;
      end
      default: begin
        if (s1_kind_q == K_WIDE && !s1_hit_q) begin
          job.bytes = s1_bytes_q;
          job.n     = s1_n_q;
        end else if (ent[21] || ecp > CpMax) begin
          job.n = 3'd0;
        end else if (ecp <= 21'h7F) begin
          job.bytes[0] = ecp[7:0];
          job.n        = 3'd1;
        end else if (ecp <= 21'h7FF) begin
          job.bytes[0] = {3'b110, ecp[10:6]};
          job.bytes[1] = {2'b10, ecp[5:0]};
          job.n        = 3'd2;
        end else if (ecp <= 21'hFFFF) begin
          job.bytes[0] = {4'b1110, ecp[15:12]};
          job.bytes[1] = {2'b10, ecp[11:6]};
          job.bytes[2] = {2'b10, ecp[5:0]};
          job.n        = 3'd3;
        end else begin
          job.bytes[0] = {5'b11110, ecp[20:18]};
          job.bytes[1] = {2'b10, ecp[17:12]};
          job.bytes[2] = {2'b10, ecp[11:6]};
          job.bytes[3] = {2'b10, ecp[5:0]};
          job.n        = 3'd4;
        end
      end
    endcase
  end

  assign q_push_o = s1_vld_q && (job.n != 3'd0);
  assign q_job_o  = job;

endmodule

// File: rtl/core/utf8ct_queue.sv
`timescale 1ns / 1ps

module utf8ct_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  utf8ct_pkg::job_t             job_i,
  input  logic                         pop_i,
  output utf8ct_pkg::job_t             job_o,
  output logic                         empty_o,
  output logic [utf8ct_pkg::QCntW-1:0] count_o
);
  import utf8ct_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(QDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign job_o   = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= nxt(wptr_q);
      if (pop_i)  rptr_q <= nxt(rptr_q);
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= job_i;
  end

endmodule

// File: rtl/core/utf8ct_back.sv
`timescale 1ns / 1ps

module utf8ct_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  utf8ct_pkg::job_t q_job_i,
  output logic             q_pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [7:0]       m_tdata_o,
  output logic [1:0]       m_tuser_o,
  output logic             m_tlast_o
);
  import utf8ct_pkg::*;

  logic       vld_q;
  logic [1:0] idx_q;
  logic [7:0] byte_q;
  logic [1:0] user_q;
  logic       last_q;
  logic       load;
  logic       fin;

  assign load    = (!vld_q || m_tready_i) && !q_empty_i;
  assign fin     = ({1'b0, idx_q} + 3'd1) == q_job_i.n;
  assign q_pop_o = load && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= fin ? 2'd0 : idx_q + 2'd1;
      end else if (m_tready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= q_job_i.bytes[idx_q];
      user_q <= {q_job_i.full, q_job_i.term && fin};
      last_q <= fin;
    end
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = byte_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = last_q;

endmodule

// File: rtl/core/utf8_char_translate.sv
`timescale 1ns / 1ps

// UTF-8 character translator. Text bytes, end-of-row marks and table writes
// arrive as one word each on the slave side. An ASCII byte is mapped through a
// 128-entry table; a multi-byte sequence is gathered by its lead-byte length,
// decoded and matched against a small associative table of wide code points.
// A hit emits the replacement re-encoded as 1 to 4 bytes, or nothing when the
// entry carries a delete mark or a code point above U+10FFFF; a miss copies the
// original bytes. End of row flushes an unfinished sequence raw and then emits
// a zero with row_end set. A wide write with no free slot emits one word with
// table_full set. Clear tables takes effect at once and keeps a pending
// sequence. Throughput: one input word per cycle, taken while the output
// stalls as long as the four-entry job queue has room; output words go out
// one at a time as the master side accepts them, so a character that expands
// to N bytes holds the output for N words. The first output word follows its
// input word through the table read at the accept edge, the queue write and
// the output register. The wide table is compared in parallel across all
// filled slots of its WideEntries in the accept cycle.
module utf8_char_translate #(
  parameter int unsigned WideEntries = utf8ct_pkg::WideEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [55:0] s_tdata_i,  // data_byte[7:0], key[28:8], value[49:29], drop[50]
  input  logic [2:0]  s_tuser_i,  // command[2:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,  // out_byte[7:0]
  output logic [1:0]  m_tuser_o,  // row_end[0], table_full[1]
  output logic        m_tlast_o
);
  import utf8ct_pkg::*;

  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  job_t             q_in;
  job_t             q_out;
  logic [QCntW-1:0] q_count;

  // Front: decode, gather sequences, look up tables, resolve a burst.
  utf8ct_front #(.WideEntries(WideEntries)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .cmd_i       (s_tuser_i),
    .data_byte_i (s_tdata_i[7:0]),
    .key_i       (s_tdata_i[28:8]),
    .value_i     (s_tdata_i[49:29]),
    .drop_i      (s_tdata_i[50]),
    .q_count_i   (q_count),
    .q_push_o    (q_push),
    .q_job_o     (q_in)
  );

  // Queue: absorb bursts so the front keeps taking words.
  utf8ct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .pop_i   (q_pop),
    .job_o   (q_out),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  // Back: serialize each burst one word per cycle while the master side accepts.
  utf8ct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_job_i    (q_out),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  // Terminator is a zero closing its burst.
  a_row_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |-> m_tlast_o && (m_tdata_o == 8'h00))
    else $error("row terminator malformed");

  a_full_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[1] |-> m_tlast_o && !m_tuser_o[0])
    else $error("table full status malformed");

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count <= QCntW'(QDepth)) && !(q_pop && q_empty))
    else $error("job queue overflow or underflow");

endmodule

// File: tb/utf8_char_translate_tb.sv
`timescale 1ns / 1ps

module utf8_char_translate_tb;
  import utf8ct_pkg::*;

  localparam int unsigned NWide = 32;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  data_byte;
    logic [20:0] key;
    logic [20:0] value;
    logic        drop;
  } word_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       row_end;
    logic       last;
    logic       table_full;
  } out_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [55:0] s_tdata_i = '0;  // data_byte[7:0], key[28:8], value[49:29], drop[50]
  logic [2:0]  s_tuser_i = CMD_TEXT;  // command[2:0]
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [7:0]  m_tdata_o;  // out_byte[7:0]
  logic [1:0]  m_tuser_o;  // row_end[0], table_full[1]
  logic        m_tlast_o;

  utf8_char_translate dut (.*);

  always #4 clk_i = ~clk_i;

  // Predictor copy of the tables and the gather state.
  logic [21:0] tb_ascii_map [128];
  logic [20:0] map_keys  [NWide];
  logic [21:0] map_vals  [NWide];
  int unsigned map_used;
  logic [7:0]  gather [4];
  int unsigned gather_cnt, gather_len;

  word_t       pending_words[$];
  out_word_t   expected_bytes[$];
  int          n_errors, n_checked, n_sent, n_rows;
  int unsigned cycles;
  bit          stim_done;

  function automatic void clear_maps();
    for (int i = 0; i < 128; i++) tb_ascii_map[i] = 22'(i);
    for (int i = 0; i < NWide; i++) begin
      map_keys[i] = '0;
      map_vals[i] = '0;
    end
    map_used = 0;
  endfunction

  function automatic void push_byte(logic [7:0] b, logic re, logic full);
    out_word_t w;
    w.out_byte = b;
    w.row_end = re;
    w.last = 1'b0;
    w.table_full = full;
    expected_bytes.push_back(w);
  endfunction

  function automatic void encode_cp(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_byte(cp[7:0], 1'b0, 1'b0);
    end else if (cp <= 21'h7FF) begin
      push_byte(8'hC0 | cp[10:6], 1'b0, 1'b0);
      push_byte(8'h80 | cp[5:0], 1'b0, 1'b0);
    end else if (cp <= 21'hFFFF) begin
      push_byte(8'hE0 | cp[15:12], 1'b0, 1'b0);
      push_byte(8'h80 | cp[11:6], 1'b0, 1'b0);
      push_byte(8'h80 | cp[5:0], 1'b0, 1'b0);
    end else if (cp <= CpMax) begin
      push_byte(8'hF0 | cp[20:18], 1'b0, 1'b0);
      push_byte(8'h80 | cp[17:12], 1'b0, 1'b0);
      push_byte(8'h80 | cp[11:6], 1'b0, 1'b0);
      push_byte(8'h80 | cp[5:0], 1'b0, 1'b0);
    end
  endfunction

  function automatic int find_wide(logic [20:0] cp);
    for (int i = 0; i < map_used; i++)
      if (map_keys[i] == cp) return i;
    return -1;
  endfunction

  // Decode a gathered sequence, then map it or copy it raw.
  function automatic void resolve_seq(int unsigned len);
    logic [20:0] cp;
    int hit;
    case (len)
      2: cp = 21'({gather[0][4:0], gather[1][5:0]});
      3: cp = 21'({gather[0][3:0], gather[1][5:0], gather[2][5:0]});
      4: cp = {gather[0][2:0], gather[1][5:0], gather[2][5:0], gather[3][5:0]};
      default: cp = 21'(gather[0]);
    endcase
    hit = find_wide(cp);
    if (hit >= 0) begin
      if (!map_vals[hit][21]) encode_cp(map_vals[hit][20:0]);
    end else begin
      for (int i = 0; i < len; i++) push_byte(gather[i], 1'b0, 1'b0);
    end
  endfunction

  function automatic int unsigned lead_len(logic [7:0] b);
    if (b < 8'hC0 || b >= 8'hF8) return 1;
    if (b < 8'hE0) return 2;
    if (b < 8'hF0) return 3;
    return 4;
  endfunction

  function automatic void translate_word(word_t w);
    int unsigned before_n;
    int hit;
    before_n = expected_bytes.size();
    case (w.cmd)
      CMD_TEXT: begin
        if (gather_cnt > 0) begin
          gather[gather_cnt] = w.data_byte;
          if (gather_cnt + 1 >= gather_len) begin
            resolve_seq(gather_len);
            gather_cnt = 0;
            gather_len = 0;
          end else begin
            gather_cnt++;
          end
        end else if (w.data_byte <= AsciiLast) begin
          if (!tb_ascii_map[w.data_byte[6:0]][21])
            encode_cp(tb_ascii_map[w.data_byte[6:0]][20:0]);
        end else begin
          gather[0] = w.data_byte;
          if (lead_len(w.data_byte) == 1) begin
            resolve_seq(1);
          end else begin
            gather_cnt = 1;
            gather_len = lead_len(w.data_byte);
          end
        end
      end
      CMD_EOR: begin
        for (int i = 0; i < gather_cnt; i++) push_byte(gather[i], 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        gather_cnt = 0;
        gather_len = 0;
      end
      CMD_SET_ASCII: begin
        if (w.key < 128) tb_ascii_map[w.key[6:0]] = {w.drop, w.value};
      end
      CMD_SET_WIDE: begin
        hit = find_wide(w.key);
        if (hit >= 0) begin
          map_vals[hit] = {w.drop, w.value};
        end else if (map_used < NWide) begin
          map_keys[map_used] = w.key;
          map_vals[map_used] = {w.drop, w.value};
          map_used++;
        end else begin
          push_byte(8'h00, 1'b0, 1'b1);
        end
      end
      CMD_CLEAR: clear_maps();
      default: ;
    endcase
    if (expected_bytes.size() > before_n)
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  function automatic word_t mk(cmd_e c, logic [7:0] b, logic [20:0] k, logic [20:0] v,
                               logic d);
    word_t w;
    w.cmd = c;
    w.data_byte = b;
    w.key = k;
    w.value = v;
    w.drop = d;
    return w;
  endfunction

  function automatic void queue_text(logic [7:0] b);
    pending_words.push_back(mk(CMD_TEXT, b, 21'($urandom), 21'($urandom), 1'($urandom)));
  endfunction

  // Queue one character, encoded as one to four bytes by its range.
  function automatic void queue_char(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      queue_text(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      queue_text(8'hC0 | cp[10:6]);
      queue_text(8'h80 | cp[5:0]);
    end else if (cp <= 21'hFFFF) begin
      queue_text(8'hE0 | cp[15:12]);
      queue_text(8'h80 | cp[11:6]);
      queue_text(8'h80 | cp[5:0]);
    end else begin
      queue_text(8'hF0 | cp[20:18]);
      queue_text(8'h80 | cp[17:12]);
      queue_text(8'h80 | cp[11:6]);
      queue_text(8'h80 | cp[5:0]);
    end
  endfunction

  function automatic logic [20:0] rand_cp();
    case ($urandom_range(0, 4))
      0: return 21'($urandom_range(0, 127));
      1: return 21'($urandom_range(128, 16'h7FF));
      2: return 21'($urandom_range(16'h800, 16'hFFFF));
      3: return 21'($urandom_range(32'h10000, 32'h10FFFF));
      default: return 21'($urandom);
    endcase
  endfunction

  logic [20:0] wide_keys_used[$];

  initial begin
    logic [20:0] k;
    clear_maps();
    gather_cnt = 0;
    gather_len = 0;
    // Directed: identity ASCII, raw misses, stray bytes, three- and four-byte remaps, deletes.
    queue_text(8'h00);
    queue_text(8'h7F);
    queue_text(8'h80);
    queue_text(8'hFF);
    queue_char(21'h10FFFF);
    pending_words.push_back(mk(CMD_SET_ASCII, 8'h00, 21'h41, 21'h1F600, 1'b0));
    pending_words.push_back(mk(CMD_SET_ASCII, 8'h00, 21'h42, 21'h0, 1'b1));
    pending_words.push_back(mk(CMD_SET_ASCII, 8'h00, 21'h1FFFFF, 21'h1FFFFF, 1'b1));
    pending_words.push_back(mk(CMD_SET_WIDE, 8'h00, 21'hE9, 21'h1FFFFF, 1'b0));
    pending_words.push_back(mk(CMD_SET_WIDE, 8'h00, 21'h20AC, 21'h7FF, 1'b0));
    pending_words.push_back(mk(CMD_SET_WIDE, 8'h00, 21'h20AC, 21'h800, 1'b0));
    pending_words.push_back(mk(CMD_SET_WIDE, 8'h00, 21'hFF, 21'h0, 1'b1));
    queue_text(8'h41);
    queue_text(8'h42);
    queue_char(21'hE9);
    queue_char(21'h20AC);
    queue_text(8'hFF);
    queue_text(8'hF3);
    queue_text(8'hBF);
    pending_words.push_back(mk(CMD_EOR, 8'h00, 21'h0, 21'h0, 1'b0));
    pending_words.push_back(mk(CMD_CLEAR, 8'h00, 21'h0, 21'h0, 1'b0));
    queue_text(8'h41);
    pending_words.push_back(mk(cmd_e'(3'd7), 8'hFF, 21'h1FFFFF, 21'h1FFFFF, 1'b1));
    pending_words.push_back(mk(CMD_EOR, 8'h00, 21'h0, 21'h0, 1'b0));
    // Fill the wide table past capacity to hit the full status.
    for (int i = 0; i < NWide + 2; i++) begin
      k = rand_cp();
      wide_keys_used.push_back(k);
      pending_words.push_back(mk(CMD_SET_WIDE, 8'h00, k, rand_cp(),
                                 ($urandom_range(0, 5) == 0)));
    end
    // Random: mostly characters, some drawn from table keys, with broken rows and writes.
    while (pending_words.size() < 320) begin
      case ($urandom_range(0, 19))
        0: pending_words.push_back(mk(CMD_EOR, 8'h00, 21'($urandom), 21'($urandom),
                                      1'($urandom)));
        1: pending_words.push_back(mk(CMD_SET_ASCII, 8'h00, 21'($urandom_range(0, 200)),
                                      rand_cp(), ($urandom_range(0, 3) == 0)));
        2: pending_words.push_back(mk(CMD_SET_WIDE, 8'h00,
                                      wide_keys_used[$urandom_range(0, wide_keys_used.size()-1)],
                                      rand_cp(), 1'($urandom)));
        3: queue_text(8'($urandom));
        4: if ($urandom_range(0, 5) == 0)
             pending_words.push_back(mk(CMD_CLEAR, 8'h00, 21'h0, 21'h0, 1'b0));
           else
             pending_words.push_back(mk(cmd_e'($urandom_range(5, 7)), 8'($urandom),
                                        21'($urandom), 21'($urandom), 1'($urandom)));
        5, 6, 7, 8, 9: queue_char(wide_keys_used[$urandom_range(0, wide_keys_used.size()-1)]);
        default: queue_char(rand_cp());
      endcase
    end
    pending_words.push_back(mk(CMD_EOR, 8'h00, 21'h0, 21'h0, 1'b0));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid_i && s_tready_o) begin
        translate_word(pending_words.pop_front());
        n_sent++;
      end
      if (!(s_tvalid_i && !s_tready_o)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0 || pending_words.size() == 0) begin
          s_tvalid_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          s_tvalid_i <= 1'b1;
          s_tuser_i <= pending_words[0].cmd;
          s_tdata_i <= {5'b0, pending_words[0].drop, pending_words[0].value,
                        pending_words[0].key, pending_words[0].data_byte};
          burst_left--;
        end
      end
      stim_done = (pending_words.size() == 0) && !(s_tvalid_i && !s_tready_o);
    end
  end

  // Receiver: stalls on its own mode, swapping between free flow and choppy.
  int stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
      stall_mode = 0;
    end else begin
      cycles++;
      if (m_tvalid_o && m_tready_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected word byte=%h user=%b last=%b", $time, m_tdata_o,
                   m_tuser_o, m_tlast_o);
          n_errors++;
        end else begin
          exp_w = expected_bytes.pop_front();
          n_checked++;
          if (exp_w.row_end) n_rows++;
          if (m_tdata_o !== exp_w.out_byte || m_tuser_o !== {exp_w.table_full, exp_w.row_end}
              || m_tlast_o !== exp_w.last) begin
            $display("%0t: mismatch expected byte=%h user=%b last=%b actual byte=%h user=%b last=%b",
                     $time, exp_w.out_byte, {exp_w.table_full, exp_w.row_end}, exp_w.last,
                     m_tdata_o, m_tuser_o, m_tlast_o);
            n_errors++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready_i <= 1'b1;
        1: m_tready_i <= ($urandom_range(0, 3) != 0);
        default: m_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    wait (rst_ni && stim_done && expected_bytes.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("checked %0d output words from %0d input words, %0d rows ended",
             n_checked, n_sent, n_rows);
    if (n_errors == 0 && expected_bytes.size() == 0)
      $display("utf8_char_translate_tb: clean");
    else
      $display("utf8_char_translate_tb: errors");
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("timeout after %0d cycles", cycles);
    $display("utf8_char_translate_tb: errors");
    $finish;
  end

endmodule
